FILE: hdl/assert_macros.svh
// assertion macros used by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BBPA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bbpa assertion failed");

// checked at every edge, reset included
`define BBPA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("bbpa assertion failed");

`endif

FILE: hdl/bbpa_pkg.sv
// package for the bitmap block pool allocator: sizes, status codes, register indexes
`timescale 1ns / 1ps
`default_nettype none

package bbpa_pkg;

  localparam int MAX_BLOCKS    = 256;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WORD_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);

  localparam int ADDR_W   = 32;
  localparam int BSIZE_W  = 16;
  localparam int LEN_W    = 9;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = INDEX_W + BSIZE_W;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_LENGTH  = 2'd2;

  localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE   = 16'd4;
  localparam logic [LEN_W-1:0]   RST_POOL_LENGTH  = 9'd256;

endpackage

`default_nettype wire

FILE: hdl/bbpa_if.sv
// request and response channel interfaces of the allocator
`timescale 1ns / 1ps
`default_nettype none

interface bbpa_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [bbpa_pkg::ADDR_W-1:0] free_address;

  modport source (output valid, output operation, output free_address, input ready);
  modport sink   (input valid, input operation, input free_address, output ready);
endinterface

interface bbpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bbpa_pkg::STATUS_W-1:0] status;
  logic [bbpa_pkg::ADDR_W-1:0]   block_address;
  logic [bbpa_pkg::INDEX_W-1:0]  block_index;

  modport source (output valid, output status, output block_address, output block_index,
                  input ready);
  modport sink   (input valid, input status, input block_address, input block_index,
                  output ready);
endinterface

`default_nettype wire

FILE: hdl/bbpa_div.sv
// restoring divider, one quotient bit per cycle through a shared subtractor
`timescale 1ns / 1ps
`default_nettype none

module bbpa_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [bbpa_pkg::ADDR_W-1:0]   dividend_i,
  input  wire logic [bbpa_pkg::BSIZE_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic [bbpa_pkg::ADDR_W-1:0]        quotient_o
);

  localparam int CNT_W = $clog2(bbpa_pkg::ADDR_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [bbpa_pkg::BSIZE_W-1:0]  rem_q, rem_d;
  logic [bbpa_pkg::ADDR_W-1:0]   quo_q, quo_d;
  logic [bbpa_pkg::BSIZE_W-1:0]  dvs_q, dvs_d;

  logic [bbpa_pkg::BSIZE_W:0]    shifted;
  logic [bbpa_pkg::BSIZE_W+1:0]  trial;
  logic                          borrow;

  assign shifted = {rem_q, quo_q[bbpa_pkg::ADDR_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign borrow  = trial[bbpa_pkg::BSIZE_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits are enough
      rem_d = borrow ? shifted[bbpa_pkg::BSIZE_W-1:0] : trial[bbpa_pkg::BSIZE_W-1:0];
      quo_d = {quo_q[bbpa_pkg::ADDR_W-2:0], ~borrow};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hdl/bitmap_block_pool_allocator.sv
// bitmap block pool allocator: sequencer, used-block map, scan and address logic
// allocate: take the request, scan 1 to 8 map words (one word a cycle), multiply, add,
//   then the result register
// free: a bit-serial divider finds the block index; it is skipped for zero block size
// one request at a time; a finished result may wait in the output register while
//   the next request is taken. reset (async, active low) clears the map, config and control registers
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bitmap_block_pool_allocator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bbpa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bbpa_pkg::ADDR_W-1:0]      cfg_data_i,
  bbpa_req_if.sink                              req_i,
  bbpa_rsp_if.source                            rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [bbpa_pkg::WORD_W-1:0] LAST_WORD =
    bbpa_pkg::WORD_W'(bbpa_pkg::MAP_WORDS - 1);
  localparam int REM_W = bbpa_pkg::LEN_W + 1;

  // configuration
  logic [bbpa_pkg::ADDR_W-1:0]  base_q;
  logic [bbpa_pkg::BSIZE_W-1:0] bsize_q;
  logic [bbpa_pkg::LEN_W-1:0]   plen_q;
  logic                         cfg_hit;
  logic [bbpa_pkg::LEN_W-1:0]   len_eff;

  // sequencer and result
  logic [2:0]                     state_q;
  logic [bbpa_pkg::WORD_W-1:0]    word_q;
  logic [bbpa_pkg::INDEX_W-1:0]   idx_q;
  logic [bbpa_pkg::PROD_W-1:0]    prod_q;
  logic [bbpa_pkg::STATUS_W-1:0]  res_status_q;
  logic [bbpa_pkg::ADDR_W-1:0]    res_addr_q;
  logic                           out_valid_q;
  logic [bbpa_pkg::STATUS_W-1:0]  out_status_q;
  logic [bbpa_pkg::ADDR_W-1:0]    out_addr_q;
  logic [bbpa_pkg::INDEX_W-1:0]   out_index_q;

  // used-block map
  logic [bbpa_pkg::MAP_WORD_BITS-1:0] map_q [bbpa_pkg::MAP_WORDS];

  // scan datapath
  logic [REM_W-1:0]                   rem_len;
  logic [bbpa_pkg::MAP_WORD_BITS-1:0] len_mask;
  logic [bbpa_pkg::MAP_WORD_BITS-1:0] free_vec;
  logic                               found;
  logic [bbpa_pkg::BIT_W-1:0]         hit_bit;

  // divider
  logic                          req_acc;
  logic                          div_start;
  logic                          div_done;
  logic [bbpa_pkg::ADDR_W-1:0]   div_quo;
  logic                          q_in_range;
  logic                          out_free;

  assign cfg_hit = cfg_we_i && (cfg_idx_i == bbpa_pkg::REG_BASE_ADDRESS ||
                                cfg_idx_i == bbpa_pkg::REG_BLOCK_SIZE ||
                                cfg_idx_i == bbpa_pkg::REG_POOL_LENGTH);

  assign len_eff = (plen_q > bbpa_pkg::LEN_W'(bbpa_pkg::MAX_BLOCKS)) ?
                   bbpa_pkg::LEN_W'(bbpa_pkg::MAX_BLOCKS) : plen_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign div_start   = req_acc && req_i.operation && (bsize_q != '0);
  assign out_free    = !out_valid_q || rsp_o.ready;

  // blocks of the current word that lie below the pool length
  assign rem_len = {1'b0, len_eff} -
                   {{(REM_W - bbpa_pkg::WORD_W - bbpa_pkg::BIT_W){1'b0}},
                    word_q, {bbpa_pkg::BIT_W{1'b0}}};

  always_comb begin
    if (rem_len[REM_W-1] || rem_len == '0) begin
      len_mask = '0;
    end else if (rem_len >= REM_W'(bbpa_pkg::MAP_WORD_BITS)) begin
      len_mask = '1;
    end else begin
      len_mask = ({{(bbpa_pkg::MAP_WORD_BITS-1){1'b0}}, 1'b1} << rem_len[bbpa_pkg::BIT_W-1:0])
                 - 1'b1;
    end
  end

  assign free_vec = ~map_q[word_q] & len_mask;
  assign found    = |free_vec;

  // lowest free bit
  always_comb begin
    hit_bit = '0;
    for (int b = bbpa_pkg::MAP_WORD_BITS - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        hit_bit = bbpa_pkg::BIT_W'(b);
      end
    end
  end

  bbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (req_i.free_address - base_q),
    .divisor_i  (bsize_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign q_in_range = ~|div_quo[bbpa_pkg::ADDR_W-1:bbpa_pkg::LEN_W] &&
                      (div_quo[bbpa_pkg::LEN_W-1:0] < len_eff);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= bbpa_pkg::RST_BASE_ADDRESS;
      bsize_q <= bbpa_pkg::RST_BLOCK_SIZE;
      plen_q  <= bbpa_pkg::RST_POOL_LENGTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbpa_pkg::REG_BASE_ADDRESS: base_q  <= cfg_data_i;
        bbpa_pkg::REG_BLOCK_SIZE:   bsize_q <= cfg_data_i[bbpa_pkg::BSIZE_W-1:0];
        bbpa_pkg::REG_POOL_LENGTH:  plen_q  <= cfg_data_i[bbpa_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // map: cleared by reset and by any write to the three config registers, at most one bit set or cleared per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < bbpa_pkg::MAP_WORDS; w++) begin
        map_q[w] <= '0;
      end
    end else if (cfg_hit) begin
      for (int w = 0; w < bbpa_pkg::MAP_WORDS; w++) begin
        map_q[w] <= '0;
      end
    end else if (state_q == S_SCAN && found) begin
      map_q[word_q][hit_bit] <= 1'b1;
    end else if (state_q == S_DIV && div_done && q_in_range) begin
      map_q[div_quo[bbpa_pkg::INDEX_W-1:bbpa_pkg::BIT_W]][div_quo[bbpa_pkg::BIT_W-1:0]] <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      word_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (req_acc) begin
            word_q <= '0;
            if (!req_i.operation) begin
              state_q <= S_SCAN;
            end else if (bsize_q == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            state_q <= S_MUL;
          end else if (word_q == LAST_WORD) begin
            state_q <= S_DONE;
          end else begin
            word_q <= word_q + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_DONE;
          end
        end
        S_MUL: state_q <= S_ADD;
        S_ADD: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          // full for allocate until a free block turns up, range for free until an in-range block is freed
          res_status_q <= req_i.operation ? bbpa_pkg::ST_RANGE : bbpa_pkg::ST_FULL;
          res_addr_q   <= '0;
          idx_q        <= '0;
        end
      end
      S_SCAN: begin
        if (found) begin
          idx_q <= {word_q, hit_bit};
        end
      end
      S_DIV: begin
        if (div_done && q_in_range) begin
          res_status_q <= bbpa_pkg::ST_FREED;
          idx_q        <= div_quo[bbpa_pkg::INDEX_W-1:0];
        end
      end
      S_MUL: prod_q <= bbpa_pkg::PROD_W'(idx_q) * bbpa_pkg::PROD_W'(bsize_q);
      S_ADD: begin
        res_status_q <= bbpa_pkg::ST_ALLOCATED;
        res_addr_q   <= base_q + {{(bbpa_pkg::ADDR_W - bbpa_pkg::PROD_W){1'b0}}, prod_q};
      end
      S_DONE: begin
        if (out_free) begin
          out_status_q <= res_status_q;
          out_addr_q   <= res_addr_q;
          out_index_q  <= idx_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.block_index   = out_index_q;

  `BBPA_ASSERT(a_scan_steps, clk_i, rst_ni,
    (state_q == S_SCAN && !found && word_q != LAST_WORD) |=>
    (state_q == S_SCAN && word_q == $past(word_q) + 1'b1))
  `BBPA_ASSERT(a_alloc_in_pool, clk_i, rst_ni,
    (rsp_o.valid && rsp_o.status == bbpa_pkg::ST_ALLOCATED) |->
    ({1'b0, rsp_o.block_index} < len_eff))
  `BBPA_ASSERT(a_addr_zero, clk_i, rst_ni,
    (rsp_o.valid && rsp_o.status != bbpa_pkg::ST_ALLOCATED) |-> (rsp_o.block_address == '0))
  `BBPA_ASSERT_ALWAYS(a_div_done_in_div, clk_i,
    div_done |-> (state_q == S_DIV))

endmodule

`default_nettype wire
